// ----- hw/rtl/fsib_pkg.sv -----
// Shared constants and register codes for the fitted image blit core.
package fsib_pkg;

    // Picture memory geometry (power of two, address wraps naturally)
    localparam int PICTURE_PIXELS = 65536;
    localparam int PIC_AW         = $clog2(PICTURE_PIXELS);

    // Field widths
    localparam int SRC_W   = 9;
    localparam int GEO_W   = 12;
    localparam int SCR_W   = 13;
    localparam int COLOR_W = 24;
    localparam int CFG_IW  = 4;

    // Divider: dividend is a 12 x 9 bit product
    localparam int DVD_W   = GEO_W + SRC_W;
    localparam int CNT_W   = $clog2(DVD_W);

    // Output packing
    localparam int M_DATA_W = 56;
    localparam int S_DATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        REG_SRC_WIDTH     = 4'd0,
        REG_SRC_HEIGHT    = 4'd1,
        REG_AREA_LEFT     = 4'd2,
        REG_AREA_TOP      = 4'd3,
        REG_AREA_WIDTH    = 4'd4,
        REG_AREA_HEIGHT   = 4'd5,
        REG_SCREEN_WIDTH  = 4'd6,
        REG_SCREEN_HEIGHT = 4'd7
    } cfg_index_t;

    // Input kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

endpackage

// ----- hw/rtl/fsib_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
module fsib_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/fit_scaled_image_blit_core.sv -----
// Top level of the fitted nearest-neighbor image blit core.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata {red,green,blue}, tuser kind
//  m_*      out  tvalid/tready     tdata pixel fields, tlast last pixel
//  cfg_*    in   cfg_we            cfg_index, cfg_data
//
// A load is one RAM write. A request for a background or empty pixel goes through
// evaluation and the result step; for a picture pixel the serial divider also
// resolves one quotient bit per cycle for the column and row sample positions.
// A request at the walk origin adds one or two more divisions for the fit. Reset
// sets the area and screen sizes to one and clears the other registers and walk
// state; the picture memory is not cleared. A full output register stalls only
// the final step of a request; the input side waits while a request works.
module fit_scaled_image_blit_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: blue[7:0], green[15:8], red[23:16]
    input  logic [fsib_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: screen_col[12:0], screen_row[25:13], color[49:26],
    //          visible[50], in_picture[51], empty_res[52], zero[55:53]
    output logic [fsib_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [fsib_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [fsib_pkg::GEO_W-1:0]       cfg_data
);

    localparam int GW = fsib_pkg::GEO_W;
    localparam int SW = fsib_pkg::SRC_W;
    localparam int DW = fsib_pkg::DVD_W;
    localparam int AW = fsib_pkg::PIC_AW;
    localparam int PW = (AW > 2*SW) ? AW : 2*SW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIT1,
        ST_FIT2,
        ST_EVAL,
        ST_DIVX,
        ST_DIVY,
        ST_ADDR,
        ST_RESULT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic [SW-1:0] src_w_reg, src_h_reg;
    logic [GW-1:0] area_left_reg, area_top_reg, area_w_reg, area_h_reg;
    logic [GW-1:0] scr_w_reg, scr_h_reg;

    // Walk and fit state
    logic [AW-1:0] load_addr_reg;
    logic [GW-1:0] walk_col_reg, walk_row_reg;
    logic [GW-1:0] fit_w_reg, fit_h_reg;
    logic [GW-1:0] y_reg;
    logic [SW-1:0] sx_reg, sy_reg;
    logic          inpic_reg, empty_reg;

    // Serial divider
    logic [DW-1:0]               dvd_reg, quo_reg;
    logic [GW-1:0]               dsr_reg, rem_reg;
    logic [fsib_pkg::CNT_W-1:0]  cnt_reg;

    // Output register
    logic                             out_valid_reg;
    logic [fsib_pkg::M_DATA_W-1:0]    out_data_reg;
    logic                             out_last_reg;

    // Memory ports
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [fsib_pkg::COLOR_W-1:0] ram_rdata;

    // Divider step
    logic [GW:0]   rem_sh;
    logic          div_ge;
    logic [GW-1:0] rem_next;
    logic [DW-1:0] quo_next;
    logic          div_done;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[DW-1]};
        div_ge   = rem_sh >= {1'b0, dsr_reg};
        rem_next = div_ge ? GW'(rem_sh - {1'b0, dsr_reg}) : rem_sh[GW-1:0];
        quo_next = {quo_reg[DW-2:0], div_ge};
        div_done = cnt_reg == fsib_pkg::CNT_W'(DW - 1);
    end

    // Per-pixel evaluation
    logic          src_zero, empty_now, in_x, in_y;
    logic [GW-1:0] off_x, off_y, rel_x, rel_y;
    logic [PW-1:0] addr_prod;

    always_comb
    begin
        src_zero  = (src_w_reg == '0) || (src_h_reg == '0);
        empty_now = src_zero || (fit_w_reg == '0) || (fit_h_reg == '0);
        off_x     = (area_w_reg >= fit_w_reg) ? GW'((area_w_reg - fit_w_reg) >> 1) : '0;
        off_y     = (area_h_reg >= fit_h_reg) ? GW'((area_h_reg - fit_h_reg) >> 1) : '0;
        rel_x     = walk_col_reg - off_x;
        rel_y     = walk_row_reg - off_y;
        in_x      = (walk_col_reg >= off_x) && (rel_x < fit_w_reg);
        in_y      = (walk_row_reg >= off_y) && (rel_y < fit_h_reg);
        addr_prod = PW'(sy_reg) * PW'(src_w_reg) + PW'(sx_reg);
    end

    // Result fields
    logic [GW:0]   next_col, next_row;
    logic          row_end, area_end;
    logic [fsib_pkg::SCR_W-1:0] out_col, out_row;
    logic          out_vis;
    logic [fsib_pkg::COLOR_W-1:0] out_color;

    always_comb
    begin
        next_col  = {1'b0, walk_col_reg} + 1'b1;
        next_row  = {1'b0, walk_row_reg} + 1'b1;
        row_end   = next_col >= {1'b0, area_w_reg};
        area_end  = row_end && (next_row >= {1'b0, area_h_reg});
        out_col   = {1'b0, area_left_reg} + {1'b0, walk_col_reg};
        out_row   = {1'b0, area_top_reg} + {1'b0, walk_row_reg};
        out_vis   = (out_col < {1'b0, scr_w_reg}) && (out_row < {1'b0, scr_h_reg});
        out_color = inpic_reg ? ram_rdata : '0;
    end

    assign ram_we    = (state_reg == ST_IDLE) && s_tvalid && (s_tuser == fsib_pkg::KIND_LOAD);
    assign ram_re    = state_reg == ST_ADDR;
    assign ram_raddr = addr_prod[AW-1:0];
    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    fsib_ram #(
        .WIDTH (fsib_pkg::COLOR_W),
        .DEPTH (fsib_pkg::PICTURE_PIXELS)
    ) u_pic_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_addr_reg),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_w_reg     <= '0;
            src_h_reg     <= '0;
            area_left_reg <= '0;
            area_top_reg  <= '0;
            area_w_reg    <= GW'(1);
            area_h_reg    <= GW'(1);
            scr_w_reg     <= GW'(1);
            scr_h_reg     <= GW'(1);
            load_addr_reg <= '0;
            walk_col_reg  <= '0;
            walk_row_reg  <= '0;
            fit_w_reg     <= '0;
            fit_h_reg     <= '0;
            y_reg         <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            inpic_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            dvd_reg       <= '0;
            quo_reg       <= '0;
            dsr_reg       <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // Write configuration
            if (cfg_we)
            begin
                case (cfg_index)
                    fsib_pkg::REG_SRC_WIDTH:     src_w_reg     <= cfg_data[SW-1:0];
                    fsib_pkg::REG_SRC_HEIGHT:    src_h_reg     <= cfg_data[SW-1:0];
                    fsib_pkg::REG_AREA_LEFT:     area_left_reg <= cfg_data;
                    fsib_pkg::REG_AREA_TOP:      area_top_reg  <= cfg_data;
                    fsib_pkg::REG_AREA_WIDTH:    area_w_reg    <= cfg_data;
                    fsib_pkg::REG_AREA_HEIGHT:   area_h_reg    <= cfg_data;
                    fsib_pkg::REG_SCREEN_WIDTH:  scr_w_reg     <= cfg_data;
                    fsib_pkg::REG_SCREEN_HEIGHT: scr_h_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // Drop the output once taken, unless a new pixel replaces it
            if (out_valid_reg && m_tready && state_reg != ST_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end

            // Advance the divider in any dividing state until the last bit
            if ((state_reg == ST_FIT1 || state_reg == ST_FIT2 ||
                 state_reg == ST_DIVX || state_reg == ST_DIVY) && !div_done)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tuser == fsib_pkg::KIND_LOAD)
                    begin
                        load_addr_reg <= load_addr_reg + 1'b1;
                    end
                    else if (s_tvalid)
                    begin
                        if (walk_col_reg == '0 && walk_row_reg == '0)
                        begin
                            if (src_zero)
                            begin
                                fit_w_reg <= '0;
                                fit_h_reg <= '0;
                                state_reg <= ST_EVAL;
                            end
                            else
                            begin
                                // fit_h = src_h * area_w / src_w
                                dvd_reg   <= DW'(src_h_reg) * DW'(area_w_reg);
                                dsr_reg   <= GW'(src_w_reg);
                                rem_reg   <= '0;
                                quo_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= ST_FIT1;
                            end
                        end
                        else
                        begin
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_FIT1:
                begin
                    if (div_done)
                    begin
                        if (quo_next > DW'(area_h_reg))
                        begin
                            // Height bound: fit_w = src_w * area_h / src_h
                            fit_h_reg <= area_h_reg;
                            dvd_reg   <= DW'(src_w_reg) * DW'(area_h_reg);
                            dsr_reg   <= GW'(src_h_reg);
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_FIT2;
                        end
                        else
                        begin
                            fit_w_reg <= area_w_reg;
                            fit_h_reg <= quo_next[GW-1:0];
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_FIT2:
                begin
                    if (div_done)
                    begin
                        fit_w_reg <= quo_next[GW-1:0];
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    empty_reg <= empty_now;
                    y_reg     <= rel_y;
                    if (!empty_now && in_x && in_y)
                    begin
                        inpic_reg <= 1'b1;
                        dvd_reg   <= DW'(rel_x) * DW'(src_w_reg);
                        dsr_reg   <= fit_w_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVX;
                    end
                    else
                    begin
                        inpic_reg <= 1'b0;
                        state_reg <= ST_RESULT;
                    end
                end
                ST_DIVX:
                begin
                    if (div_done)
                    begin
                        sx_reg    <= quo_next[SW-1:0];
                        dvd_reg   <= DW'(y_reg) * DW'(src_h_reg);
                        dsr_reg   <= fit_h_reg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIVY;
                    end
                end
                ST_DIVY:
                begin
                    if (div_done)
                    begin
                        sy_reg    <= quo_next[SW-1:0];
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    // Hold until the output register is free, then step the walk
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= area_end;
                        out_data_reg  <= {3'b000, empty_reg, inpic_reg, out_vis,
                                          out_color, out_row, out_col};
                        if (row_end)
                        begin
                            walk_col_reg <= '0;
                            walk_row_reg <= area_end ? '0 : next_row[GW-1:0];
                        end
                        else
                        begin
                            walk_col_reg <= next_col[GW-1:0];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A picture pixel never comes with the empty flag
    a_inpic_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[51] && m_tdata[52]))
        else $error("in_picture set on an empty result");

    // A background pixel is black
    a_bg_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[51]) |-> (m_tdata[49:26] == '0))
        else $error("background pixel not black");

    // The picture memory is read only after both divisions
    a_read_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> $past(state_reg == ST_DIVY))
        else $error("memory read without sample position");

    // The divider count stays within the dividend width
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fsib_pkg::CNT_W'(DW - 1))
        else $error("divider count out of range");
`endif

endmodule

// ----- tb/tb_fit_scaled_image_blit_core.sv -----
// Self-checking testbench for the fitted nearest-neighbor image blit core.
module tb_fit_scaled_image_blit_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int TAIL_CYCLES = 200;

    typedef struct packed {
        logic [fsib_pkg::SCR_W-1:0]   col;
        logic [fsib_pkg::SCR_W-1:0]   row;
        logic [fsib_pkg::COLOR_W-1:0] color;
        logic                         visible;
        logic                         in_pic;
        logic                         empty;
        logic                         last;
    } pixel_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [fsib_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [fsib_pkg::M_DATA_W-1:0] m_tdata;
    logic                          m_tlast;
    logic                          cfg_we;
    logic [fsib_pkg::CFG_IW-1:0]   cfg_index;
    logic [fsib_pkg::GEO_W-1:0]    cfg_data;

    // Predictor state
    logic [fsib_pkg::GEO_W-1:0]   geo_reg [8];
    logic [fsib_pkg::COLOR_W-1:0] pic_mem [fsib_pkg::PICTURE_PIXELS];
    logic [fsib_pkg::PIC_AW-1:0]  load_ptr;
    int unsigned                  walk_x, walk_y, fit_w, fit_h;

    pixel_t pixel_queue[$];
    int     errors;
    int     cycles;
    bit     idle_on;
    bit     hold_sink;
    int     hold_cycles;

    fit_scaled_image_blit_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_fit_scaled_image_blit_core: FAIL");
            $finish;
        end
    end

    // Drive the receiver ready with bursts of stall, or a long hold-off
    always @(negedge clk)
    begin
        if (hold_sink)
            m_tready <= 1'b0;
        else if (idle_on && $urandom_range(0, 3) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Hold the receiver off for a counted stretch when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_sink <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            hold_sink <= 1'b0;
    end

    // Check each accepted pixel against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[12:0], m_tdata[25:13], m_tdata[49:26], m_tdata[50],
                    m_tdata[51], m_tdata[52], m_tlast};
            if (pixel_queue.size() == 0)
            begin
                $display("%0t: unexpected pixel %h", $realtime, got);
                errors++;
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (got !== want || m_tdata[55:53] !== 3'b0)
                begin
                    $display("%0t: pixel mismatch expected %h actual %h (pad %b)",
                             $realtime, want, got, m_tdata[55:53]);
                    errors++;
                end
            end
        end
    end

    // Latch the fit of the picture into the area
    task automatic latch_fit();
        int unsigned sw, sh, aw, ah, fw, fh;
        sw = geo_reg[fsib_pkg::REG_SRC_WIDTH];
        sh = geo_reg[fsib_pkg::REG_SRC_HEIGHT];
        aw = geo_reg[fsib_pkg::REG_AREA_WIDTH];
        ah = geo_reg[fsib_pkg::REG_AREA_HEIGHT];
        fw = 0;
        fh = 0;
        if (sw != 0 && sh != 0)
        begin
            fw = aw;
            fh = (sh * fw) / sw;
            if (fh > ah)
            begin
                fh = ah;
                fw = (sw * fh) / sh;
            end
        end
        fit_w = fw & 12'hFFF;
        fit_h = fh & 12'hFFF;
    endtask

    // Predict the pixel that one request gives and advance the walk
    task automatic predict_pixel();
        pixel_t      p;
        int unsigned sw, sh, aw, ah, ox, oy, cx, cy;
        sw = geo_reg[fsib_pkg::REG_SRC_WIDTH];
        sh = geo_reg[fsib_pkg::REG_SRC_HEIGHT];
        aw = geo_reg[fsib_pkg::REG_AREA_WIDTH];
        ah = geo_reg[fsib_pkg::REG_AREA_HEIGHT];
        if (walk_x == 0 && walk_y == 0)
            latch_fit();
        cx = geo_reg[fsib_pkg::REG_AREA_LEFT] + walk_x;
        cy = geo_reg[fsib_pkg::REG_AREA_TOP] + walk_y;
        p = '0;
        p.col = cx[fsib_pkg::SCR_W-1:0];
        p.row = cy[fsib_pkg::SCR_W-1:0];
        p.visible = cx < geo_reg[fsib_pkg::REG_SCREEN_WIDTH] &&
                    cy < geo_reg[fsib_pkg::REG_SCREEN_HEIGHT];
        p.empty = sw == 0 || sh == 0 || fit_w == 0 || fit_h == 0;
        if (!p.empty)
        begin
            ox = aw >= fit_w ? (aw - fit_w) / 2 : 0;
            oy = ah >= fit_h ? (ah - fit_h) / 2 : 0;
            if (walk_x >= ox && walk_x - ox < fit_w && walk_y >= oy && walk_y - oy < fit_h)
            begin
                p.color = pic_mem[(((walk_y - oy) * sh / fit_h) * sw
                                   + (walk_x - ox) * sw / fit_w) % fsib_pkg::PICTURE_PIXELS];
                p.in_pic = 1'b1;
            end
        end
        if (walk_x + 1 >= aw)
        begin
            walk_x = 0;
            if (walk_y + 1 >= ah)
            begin
                walk_y = 0;
                p.last = 1'b1;
            end
            else
                walk_y = (walk_y + 1) & 12'hFFF;
        end
        else
            walk_x = walk_x + 1;
        pixel_queue.push_back(p);
    endtask

    // Send one request or load, sometimes after a random gap
    task automatic send_item(input logic kind, input int unsigned rgb);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = rgb[23:0];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == fsib_pkg::KIND_LOAD)
        begin
            pic_mem[load_ptr] = rgb[23:0];
            load_ptr++;
        end
        else
            predict_pixel();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Wait for every prediction, then let the block settle
    task automatic drain();
        while (pixel_queue.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input fsib_pkg::cfg_index_t idx, input int val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val[fsib_pkg::GEO_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        geo_reg[idx] = idx <= fsib_pkg::REG_SRC_HEIGHT ?
                       {3'b0, val[fsib_pkg::SRC_W-1:0]} : val[fsib_pkg::GEO_W-1:0];
    endtask

    // Wait for the block to drain, then set a whole geometry
    task automatic set_geometry(input int sw, input int sh, input int al, input int at,
                                input int aw, input int ah, input int scw, input int sch);
        drain();
        write_reg(fsib_pkg::REG_SRC_WIDTH, sw);
        write_reg(fsib_pkg::REG_SRC_HEIGHT, sh);
        write_reg(fsib_pkg::REG_AREA_LEFT, al);
        write_reg(fsib_pkg::REG_AREA_TOP, at);
        write_reg(fsib_pkg::REG_AREA_WIDTH, aw);
        write_reg(fsib_pkg::REG_AREA_HEIGHT, ah);
        write_reg(fsib_pkg::REG_SCREEN_WIDTH, scw);
        write_reg(fsib_pkg::REG_SCREEN_HEIGHT, sch);
    endtask

    // Finish the current walk so the next request starts at the origin
    task automatic finish_walk();
        while (walk_x != 0 || walk_y != 0)
            send_item(fsib_pkg::KIND_REQUEST, $urandom);
    endtask

    // Load n random pixels at the next load addresses, in raster order
    task automatic load_picture(input int n);
        repeat (n) send_item(fsib_pkg::KIND_LOAD, $urandom);
    endtask

    task automatic test_directed();
        // Empty picture at reset geometry, then extremes of the color bits
        send_item(fsib_pkg::KIND_REQUEST, 24'hFFFFFF);
        load_picture(1);
        send_item(fsib_pkg::KIND_LOAD, 24'hFFFFFF);
        send_item(fsib_pkg::KIND_LOAD, 24'h000000);
        send_item(fsib_pkg::KIND_LOAD, 24'hA5C35A);
        // 2x2 picture into a wide area: side bars of background
        set_geometry(2, 2, 0, 0, 6, 3, 4, 2);
        drain();
        set_geometry(2, 2, 0, 0, 6, 3, 4, 2);
        repeat (12) send_item(fsib_pkg::KIND_REQUEST, 0);
        finish_walk();
        // Fitted size zero: tall picture into a short area
        set_geometry(1, 256, 4095, 4095, 4, 1, 4095, 4095);
        repeat (4) send_item(fsib_pkg::KIND_REQUEST, 0);
    endtask

    task automatic test_random_walks();
        int sw, sh, aw, ah;
        repeat (12)
        begin
            sw = $urandom_range(0, 5) == 0 ? ($urandom_range(0, 1) ? 256 : 0)
                                           : $urandom_range(1, 12);
            sh = $urandom_range(0, 5) == 0 ? ($urandom_range(0, 1) ? 256 : 0)
                                           : $urandom_range(1, 12);
            // Keep the picture small enough to load in a short run
            if (sw * sh > 256)
                sh = 256 / sw;
            aw = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 8);
            ah = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 6);
            // Finish only walks that are short; a large area is left mid-walk
            if ((geo_reg[fsib_pkg::REG_AREA_WIDTH] + 1) *
                (geo_reg[fsib_pkg::REG_AREA_HEIGHT] + 1) <= 100)
                finish_walk();
            set_geometry(sw, sh, $urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hFFF : 12'h7),
                         $urandom_range(0, 4095) & ($urandom_range(0, 1) ? 12'hFFF : 12'h7),
                         aw, ah, $urandom_range(1, 4095) & ($urandom_range(0, 1) ? 12'hFFF : 12'hF),
                         $urandom_range(1, 4095) & ($urandom_range(0, 1) ? 12'hFFF : 12'hF));
            // Fill the store up to the picture size so every read hits written data
            if (load_ptr < sw * sh)
                load_picture(sw * sh - load_ptr);
            else
                load_picture($urandom_range(0, 2));
            repeat ($urandom_range(5, 20))
                send_item($urandom_range(0, 7) == 0 ? fsib_pkg::KIND_LOAD
                                                    : fsib_pkg::KIND_REQUEST, $urandom);
        end
    endtask

    task automatic test_pressure();
        // Sink holds off while requests keep coming
        drain();
        hold_cycles = 400;
        repeat (20) send_item(fsib_pkg::KIND_REQUEST, 0);
        drain();
        // Mid-walk shrink of the area
        set_geometry(3, 3, 1, 1, 2, 2, 4095, 4095);
        if (load_ptr < 9)
            load_picture(9 - load_ptr);
        repeat (3) send_item(fsib_pkg::KIND_REQUEST, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        idle_on = 1'b1;
        hold_sink = 1'b0;
        hold_cycles = 0;
        load_ptr = '0;
        walk_x = 0;
        walk_y = 0;
        fit_w = 0;
        fit_h = 0;
        foreach (geo_reg[i])
            geo_reg[i] = i >= fsib_pkg::REG_AREA_WIDTH ? 12'd1 : 12'd0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_walks();
        test_pressure();
        idle_on = 1'b0;
        test_random_walks();
        drain();
        if (errors == 0)
            $display("tb_fit_scaled_image_blit_core: PASS");
        else
            $display("tb_fit_scaled_image_blit_core: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/fsib_pkg.sv
hw/rtl/fsib_ram.sv
hw/rtl/fit_scaled_image_blit_core.sv
tb/tb_fit_scaled_image_blit_core.sv
